[design/qcs_pkg.sv]
// ----------------------------------------------------------------------------
// qcs_pkg: shared types and constants for the quadrature counter
// Beat payloads, event codes, register indexes and speed scaling constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qcs_pkg;

    localparam int POS_W      = 64;
    localparam int SPEED_W    = 48;
    localparam int TIME_W     = 32;
    localparam int CPR_W      = 16;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int FRAC_BITS_DEF = 16;

    // quotient bits kept below the overflow point, and numerator width
    localparam int QUO_W = SPEED_W - 1;
    localparam int NUM_W = 128;
    localparam int REM_W = NUM_W - QUO_W;

    // 2*pi with 32 fraction bits times microseconds per second
    localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
    localparam logic [63:0] US_PER_S   = 64'd1000000;
    localparam logic [63:0] SPEED_K    = TWO_PI_Q32 * US_PER_S;

    localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W - 1){1'b1}}};
    localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W - 1){1'b0}}};

    localparam logic [1:0] FUNC_EDGE_A  = 2'd0;
    localparam logic [1:0] FUNC_EDGE_B  = 2'd1;
    localparam logic [1:0] FUNC_UPDATE  = 2'd2;
    localparam logic [1:0] FUNC_RESTART = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_DIRECTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV  = 1'd1;

    localparam logic [DIR_W-1:0] DIR_RESET = 2'd1;
    localparam logic [CPR_W-1:0] CPR_RESET = 16'd1024;

    typedef struct packed {
        logic [1:0]        func;
        logic              a_level;
        logic              b_level;
        logic [TIME_W-1:0] now_us;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   position;
        logic signed [SPEED_W-1:0] speed_q16;
        logic                      zero_interval;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;

endpackage

`default_nettype wire

[design/qcs_chan_if.sv]
// ----------------------------------------------------------------------------
// qcs_chan_if: valid/ready channel
// One beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qcs_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

`default_nettype wire

[design/quadrature_counter_with_speed.sv]
// ----------------------------------------------------------------------------
// quadrature_counter_with_speed: x4 quadrature position counter with speed
// item carries one event (A edge, B edge, speed update, baseline restart)
// with the sampled A/B levels and a microsecond timestamp. Each item gives
// exactly one result beat: the position count, the held speed (signed,
// FRAC_BITS fraction bits, saturated) and the zero-interval flag.
// cfg writes count_direction (index 0) or counts_per_rev (index 1); it is
// always ready; the user must write it only while no item is in flight,
// which the block itself does not enforce. Edges, restarts and updates with
// a zero interval go straight to the emit state; the next item is taken in
// the same cycle as their result beat goes valid.
// Speed updates: one 32x32 multiplier forms the divisor and the numerator,
// then one shared subtract/compare unit checks overflow (and saturates on it),
// runs a 47-step restoring division and the rounding step.
// item is not ready while an event is being worked on.
// Reset: count 0, baseline 0, speed 0, count_direction 1, counts_per_rev 1024.
// A stalled result sits in the output register; the next item is still
// taken and its result waits until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quadrature_counter_with_speed #(
    parameter int FRAC_BITS = qcs_pkg::FRAC_BITS_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    qcs_chan_if.sink      item,
    qcs_chan_if.source    result,
    qcs_chan_if.sink      cfg
);

    import qcs_pkg::*;

    localparam int SHIFT = 32 - FRAC_BITS;
    localparam int DEN_W = CPR_W + TIME_W + SHIFT;
    localparam int CNT_W = $clog2(QUO_W);

    localparam logic [CNT_W-1:0] MUL_DEN  = CNT_W'(0);
    localparam logic [CNT_W-1:0] MUL_LL   = CNT_W'(1);
    localparam logic [CNT_W-1:0] MUL_LH   = CNT_W'(2);
    localparam logic [CNT_W-1:0] MUL_HL   = CNT_W'(3);
    localparam logic [CNT_W-1:0] MUL_HH   = CNT_W'(4);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(5);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_OVF   = 6'b000100,
        S_DIV   = 6'b001000,
        S_ROUND = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    tag_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic [DIR_W-1:0]    dir_reg;
    logic [CPR_W-1:0]    cpr_reg;
    logic [POS_W-1:0]    count_reg;
    logic [POS_W-1:0]    base_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic                zero_reg;

    logic                neg_reg;
    logic [POS_W-1:0]    mag_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    logic [63:0]         pp_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [QUO_W-1:0]    q_reg;

    logic                item_fire;
    logic                out_free;
    logic [POS_W-1:0]    step;
    logic                forward;
    logic [POS_W-1:0]    delta;
    logic [TIME_W-1:0]   elapsed;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [NUM_W-1:0]    pp_aligned;
    logic [REM_W-1:0]    cmp_a;
    logic [REM_W:0]      diff;
    logic                ge;
    logic [SPEED_W-1:0]  q_rnd;
    logic [SPEED_W-1:0]  speed_round;
    logic [SPEED_W-1:0]  speed_sat;

    assign item.ready     = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    assign item_fire = item.valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || result.ready;

    assign step    = {{(POS_W - DIR_W){dir_reg[DIR_W-1]}}, dir_reg};
    assign forward = (item.payload.func == FUNC_EDGE_A)
                   ? (item.payload.a_level == item.payload.b_level)
                   : (item.payload.a_level != item.payload.b_level);
    assign delta   = count_reg - base_reg;
    assign elapsed = item.payload.now_us - time_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cnt_reg)
            MUL_DEN:
            begin
                mul_a = elapsed_reg;
                mul_b = 32'(cpr_reg);
            end
            MUL_LL:
            begin
                mul_a = mag_reg[31:0];
                mul_b = SPEED_K[31:0];
            end
            MUL_LH:
            begin
                mul_a = mag_reg[31:0];
                mul_b = SPEED_K[63:32];
            end
            MUL_HL:
            begin
                mul_a = mag_reg[63:32];
                mul_b = SPEED_K[31:0];
            end
            MUL_HH:
            begin
                mul_a = mag_reg[63:32];
                mul_b = SPEED_K[63:32];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // place the registered partial product at its column
    always_comb
    begin
        pp_aligned = NUM_W'(pp_reg);
        unique case (tag_reg)
            MUL_LH, MUL_HL: pp_aligned = NUM_W'(pp_reg) << 32;
            MUL_HH:         pp_aligned = NUM_W'(pp_reg) << 64;
            default:        pp_aligned = NUM_W'(pp_reg);
        endcase
    end

    // shared subtract/compare unit against the divisor
    always_comb
    begin
        cmp_a = '0;
        unique case (state_reg)
            S_OVF:   cmp_a = num_reg[NUM_W-1:QUO_W];
            S_DIV:   cmp_a = {rem_reg[REM_W-2:0], num_reg[QUO_W-1]};
            S_ROUND: cmp_a = {rem_reg[REM_W-2:0], 1'b0};
            default: cmp_a = '0;
        endcase
    end

    assign diff = {1'b0, cmp_a} - {1'b0, REM_W'(den_reg)};
    assign ge   = !diff[REM_W];

    assign q_rnd       = {1'b0, q_reg} + SPEED_W'(ge);
    assign speed_sat   = neg_reg ? SPEED_MIN : SPEED_MAX;
    assign speed_round = q_rnd[SPEED_W-1] ? speed_sat
                       : (neg_reg ? (SPEED_W'(0) - q_rnd) : q_rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            dir_reg       <= DIR_RESET;
            cpr_reg       <= CPR_RESET;
            count_reg     <= '0;
            base_reg      <= '0;
            time_reg      <= '0;
            speed_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.payload.index)
                    REG_COUNT_DIRECTION: dir_reg <= cfg.payload.data[DIR_W-1:0];
                    REG_COUNTS_PER_REV:  cpr_reg <= cfg.payload.data[CPR_W-1:0];
                    default:             cpr_reg <= cpr_reg;
                endcase
            end

            // the emit state loads the next beat itself
            if (result.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_fire)
                    begin
                        unique case (item.payload.func)
                            FUNC_EDGE_A, FUNC_EDGE_B:
                            begin
                                count_reg <= forward ? (count_reg + step)
                                                     : (count_reg - step);
                                state_reg <= S_EMIT;
                            end
                            FUNC_UPDATE:
                            begin
                                time_reg <= item.payload.now_us;
                                base_reg <= count_reg;
                                cnt_reg  <= '0;
                                if (elapsed == '0 || cpr_reg == '0)
                                begin
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_MUL;
                                end
                            end
                            FUNC_RESTART:
                            begin
                                time_reg  <= item.payload.now_us;
                                base_reg  <= count_reg;
                                state_reg <= S_EMIT;
                            end
                            default:
                            begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == MUL_LAST)
                    begin
                        state_reg <= S_OVF;
                        cnt_reg   <= '0;
                    end
                end
                S_OVF:
                begin
                    if (ge)
                    begin
                        speed_reg <= speed_sat;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    speed_reg <= speed_round;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            zero_reg    <= (item.payload.func == FUNC_UPDATE)
                        && (elapsed == '0 || cpr_reg == '0);
            neg_reg     <= delta[POS_W-1];
            mag_reg     <= delta[POS_W-1] ? (POS_W'(0) - delta) : delta;
            elapsed_reg <= elapsed;
            num_reg     <= '0;
        end

        if (state_reg == S_MUL)
        begin
            pp_reg  <= mul_a * mul_b;
            tag_reg <= cnt_reg;
            if (cnt_reg != MUL_DEN)
            begin
                if (tag_reg == MUL_DEN)
                begin
                    den_reg <= DEN_W'(pp_reg[CPR_W+TIME_W-1:0]) << SHIFT;
                end
                else
                begin
                    num_reg <= num_reg + pp_aligned;
                end
            end
        end

        if (state_reg == S_OVF)
        begin
            rem_reg <= cmp_a;
        end

        if (state_reg == S_DIV)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : cmp_a;
            q_reg   <= {q_reg[QUO_W-2:0], ge};
            num_reg <= num_reg << 1;
        end

        if (state_reg == S_EMIT && out_free)
        begin
            out_reg.position      <= count_reg;
            out_reg.speed_q16     <= speed_reg;
            out_reg.zero_interval <= zero_reg;
        end
    end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the quadrature counter with speed estimate
// A scripted table walks the edge rules, every direction step, zero interval,
// zero counts-per-rev and timestamp wrap. Random phases then follow, each with
// its own register setting: mostly clean quadrature motion, speed updates and
// baseline restarts, plus some noise beats. Two long sweeps drive the speed
// into positive and negative saturation. Every result beat is checked field by
// field against an in-bench model of the counter or a written-out row of the
// table, with random gaps on the item side and stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import qcs_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_ROWS       = 30;
    localparam int N_PHASES     = 12;
    localparam int PHASE_EVENTS = 50;
    localparam int SWEEP_EDGES  = 175;

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        item_t     it;
        cfg_t      wr;
        bit        typed;
        result_t   want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;

    qcs_chan_if #(.payload_t(item_t))   item_if ();
    qcs_chan_if #(.payload_t(result_t)) result_if ();
    qcs_chan_if #(.payload_t(cfg_t))    cfg_if ();

    quadrature_counter_with_speed #(
        .FRAC_BITS(FRAC)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always #4 clk = ~clk;

    // model state of the counter
    logic signed [POS_W-1:0]   enc_count;
    logic signed [POS_W-1:0]   mark_count;
    logic [TIME_W-1:0]         mark_time;
    logic signed [SPEED_W-1:0] held_speed;
    logic [DIR_W-1:0]          cfg_dir;
    logic [CPR_W-1:0]          cfg_cpr;

    // stimulus state: encoder levels, motion sense and free-running time
    bit                enc_a;
    bit                enc_b;
    bit                motion_fwd;
    logic [TIME_W-1:0] clock_us;
    bit                idle_on;

    result_t pending_results[$];
    row_t    script [N_ROWS];

    int n_errors;
    int n_checked;
    int n_speed;
    int n_sat;
    int n_zero;
    int cycles;

    // rounded, saturated 2*pi*delta*1e6 / (cpr * elapsed) with FRAC fraction bits
    function automatic logic [SPEED_W-1:0] angular_speed(input logic [63:0] delta,
                                                         input logic [CPR_W-1:0] res,
                                                         input logic [TIME_W-1:0] elapsed);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] rmd;
        neg = delta[63];
        mag = neg ? -delta : delta;
        num = {64'd0, mag} * {64'd0, SPEED_K};
        den = ({112'd0, res} * {96'd0, elapsed}) << (32 - FRAC);
        quo = num / den;
        rmd = num % den;
        if ((rmd << 1) >= den)
            quo = quo + 1;
        if (quo > {80'd0, SPEED_MAX})
            return neg ? SPEED_MIN : SPEED_MAX;
        if (neg)
            quo = -quo;
        return quo[SPEED_W-1:0];
    endfunction

    function automatic result_t advance_counter(input item_t it);
        logic signed [POS_W-1:0] step;
        logic [TIME_W-1:0]       elapsed;
        result_t                 r;
        bit                      fwd;
        step = {{(POS_W - DIR_W){cfg_dir[DIR_W-1]}}, cfg_dir};
        r.zero_interval = 1'b0;
        case (it.func)
            FUNC_EDGE_A, FUNC_EDGE_B:
            begin
                fwd = (it.func == FUNC_EDGE_A) ? (it.a_level == it.b_level)
                                                : (it.a_level != it.b_level);
                enc_count = fwd ? enc_count + step : enc_count - step;
            end
            FUNC_UPDATE:
            begin
                elapsed = it.now_us - mark_time;
                if (elapsed == '0 || cfg_cpr == '0)
                    r.zero_interval = 1'b1;
                else
                    held_speed = angular_speed(enc_count - mark_count, cfg_cpr, elapsed);
                mark_time  = it.now_us;
                mark_count = enc_count;
            end
            default:
            begin
                mark_time  = it.now_us;
                mark_count = enc_count;
            end
        endcase
        r.position  = enc_count;
        r.speed_q16 = held_speed;
        return r;
    endfunction

    function automatic row_t ev(input logic [1:0] f, input bit a, input bit b,
                                input logic [TIME_W-1:0] t);
        row_t r;
        r.kind  = ROW_ITEM;
        r.it    = '{func: f, a_level: a, b_level: b, now_us: t};
        r.wr    = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // speed is zero on every row whose result is written out
    function automatic row_t ev_known(input logic [1:0] f, input bit a, input bit b,
                                      input logic [TIME_W-1:0] t, input longint pos,
                                      input bit z);
        row_t r;
        r       = ev(f, a, b, t);
        r.typed = 1'b1;
        r.want  = '{position: pos, speed_q16: '0, zero_interval: z};
        return r;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        row_t r;
        r       = ev(FUNC_EDGE_A, 1'b0, 1'b0, '0);
        r.kind  = ROW_REG;
        r.wr    = '{index: idx, data: data};
        return r;
    endfunction

    // toggle whichever channel moves the count the wanted way
    function automatic item_t next_edge(input bit fwd);
        item_t it;
        if (((~enc_a) == enc_b) == fwd)
        begin
            enc_a   = ~enc_a;
            it.func = FUNC_EDGE_A;
        end
        else
        begin
            enc_b   = ~enc_b;
            it.func = FUNC_EDGE_B;
        end
        it.a_level = enc_a;
        it.b_level = enc_b;
        it.now_us  = clock_us;
        return it;
    endfunction

    function automatic item_t random_event();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            if ($urandom_range(0, 9) == 0)
                motion_fwd = ~motion_fwd;
            clock_us = clock_us + $urandom_range(0, 50);
            return next_edge(motion_fwd);
        end
        it.a_level = 1'($urandom_range(0, 1));
        it.b_level = 1'($urandom_range(0, 1));
        if (pick < 90)
        begin
            case ($urandom_range(0, 9))
                0:       clock_us = clock_us;
                1:       clock_us = clock_us + $urandom;
                default: clock_us = clock_us + $urandom_range(1, 4000);
            endcase
            it.func   = (pick < 85) ? FUNC_UPDATE : FUNC_RESTART;
            it.now_us = clock_us;
        end
        else
        begin
            // noise: any event kind, any timestamp
            it.func   = 2'($urandom_range(0, 3));
            it.now_us = $urandom;
        end
        return it;
    endfunction

    task automatic push_item(input item_t it, input bit typed = 1'b0,
                             input result_t want = '0);
        int      gap;
        result_t pred;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        do @(posedge clk); while (!item_if.ready);
        pred = advance_counter(it);
        if (it.func == FUNC_UPDATE && !pred.zero_interval)
        begin
            n_speed++;
            if (pred.speed_q16 == SPEED_MAX || pred.speed_q16 == SPEED_MIN)
                n_sat++;
        end
        if (pred.zero_interval)
            n_zero++;
        pending_results.push_back(typed ? want : pred);
    endtask

    // drop valid and hold off until every result is back
    task automatic wait_quiet(input int settle);
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= '{index: idx, data: data};
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == REG_COUNT_DIRECTION)
            cfg_dir = data[DIR_W-1:0];
        else
            cfg_cpr = data[CPR_W-1:0];
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // with cpr 1 and a 1 us interval, 350 counts of motion is past full scale
    task automatic saturation_sweep(input bit fwd);
        item_t it;
        wait_quiet(64);
        write_reg(REG_COUNT_DIRECTION, 16'h0002);
        write_reg(REG_COUNTS_PER_REV, 16'd1);
        clock_us = clock_us + $urandom_range(1, 1000);
        it = '{func: FUNC_RESTART, a_level: 1'b0, b_level: 1'b1, now_us: clock_us};
        push_item(it);
        repeat (SWEEP_EDGES) push_item(next_edge(fwd));
        clock_us  = clock_us + 1;
        it.func   = FUNC_UPDATE;
        it.now_us = clock_us;
        push_item(it);
        clock_us  = clock_us + 2;
        it.now_us = clock_us;
        push_item(it);
    endtask

    // result side: random stall before each beat
    initial
    begin
        int stall;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (result_if.valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            got = result_if.payload;
            n_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation: position %0d", got.position);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.position !== want.position)
                begin
                    $error("position: expected %0d, actual %0d",
                           want.position, got.position);
                    n_errors++;
                end
                if (got.speed_q16 !== want.speed_q16)
                begin
                    $error("speed_q16: expected %0d, actual %0d",
                           want.speed_q16, got.speed_q16);
                    n_errors++;
                end
                if (got.zero_interval !== want.zero_interval)
                begin
                    $error("zero_interval: expected %0d, actual %0d",
                           want.zero_interval, got.zero_interval);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [DIR_W-1:0] dir_val;
        logic [CPR_W-1:0] cpr_val;
        rst_n           = 1'b0;
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.payload  = '0;
        enc_count       = '0;
        mark_count      = '0;
        mark_time       = '0;
        held_speed      = '0;
        cfg_dir         = DIR_RESET;
        cfg_cpr         = CPR_RESET;
        enc_a           = 1'b0;
        enc_b           = 1'b0;
        motion_fwd      = 1'b1;
        clock_us        = '0;
        idle_on         = 1'b1;

        script = '{
            ev_known(FUNC_EDGE_A,  0, 0, 32'h0000_0000, 1, 0),
            ev_known(FUNC_EDGE_A,  1, 0, 32'hFFFF_FFFF, 0, 0),
            ev_known(FUNC_EDGE_B,  1, 0, 32'h0000_0000, 1, 0),
            ev_known(FUNC_EDGE_B,  1, 1, 32'h0000_0000, 0, 0),
            ev_known(FUNC_EDGE_B,  0, 1, 32'h0000_0000, 1, 0),
            // zero interval right after reset, then no motion over a long gap
            ev_known(FUNC_UPDATE,  1, 1, 32'h0000_0000, 1, 1),
            ev_known(FUNC_UPDATE,  0, 0, 32'hFFFF_FFFF, 1, 0),
            ev_known(FUNC_EDGE_A,  1, 1, 32'h0000_0000, 2, 0),
            ev(FUNC_UPDATE,  0, 1, 32'h0000_0001),   // timestamp wraps
            ev(FUNC_RESTART, 1, 0, 32'h8000_0000),
            reg_row(REG_COUNT_DIRECTION, 16'hFFFE),  // step of -2
            reg_row(REG_COUNTS_PER_REV,  16'hFFFF),
            ev(FUNC_EDGE_A,  0, 0, 32'h0000_0000),
            ev(FUNC_EDGE_A,  0, 1, 32'h0000_0000),
            ev(FUNC_EDGE_B,  0, 1, 32'h0000_0000),
            ev(FUNC_UPDATE,  1, 1, 32'h8000_0001),   // negative speed
            reg_row(REG_COUNT_DIRECTION, 16'h0003),
            reg_row(REG_COUNTS_PER_REV,  16'h0000),
            ev(FUNC_EDGE_A,  1, 1, 32'h0000_0000),
            ev(FUNC_UPDATE,  0, 0, 32'h9000_0000),   // zero cpr keeps speed
            ev(FUNC_RESTART, 0, 0, 32'h0000_0000),
            reg_row(REG_COUNT_DIRECTION, 16'h0000),
            reg_row(REG_COUNTS_PER_REV,  16'h0001),
            ev(FUNC_EDGE_A,  0, 0, 32'h0000_0000),
            ev(FUNC_EDGE_B,  0, 1, 32'h0000_0000),
            ev(FUNC_UPDATE,  0, 0, 32'h0000_0000),
            reg_row(REG_COUNT_DIRECTION, 16'h0001),
            ev(FUNC_EDGE_A,  0, 0, 32'h0000_0000),
            ev(FUNC_UPDATE,  1, 0, 32'h0000_0001),
            ev(FUNC_UPDATE,  1, 1, 32'hFFFF_FFFF)
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                wait_quiet(64);
                write_reg(script[i].wr.index, script[i].wr.data);
            end
            else
                push_item(script[i].it, script[i].typed, script[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            dir_val = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       cpr_val = 16'd0;
                1:       cpr_val = 16'd1;
                2:       cpr_val = 16'hFFFF;
                3:       cpr_val = 16'($urandom_range(1, 16));
                default: cpr_val = 16'($urandom_range(1, 65535));
            endcase
            wait_quiet(64);
            write_reg(REG_COUNT_DIRECTION, {14'($urandom), dir_val});
            write_reg(REG_COUNTS_PER_REV, cpr_val);
            // every third phase runs flat out on both sides
            idle_on = (ph % 3 != 2);
            repeat (PHASE_EVENTS) push_item(random_event());
        end

        idle_on = 1'b1;
        saturation_sweep(1'b0);
        saturation_sweep(1'b1);

        wait_quiet(64);
        $display("%0d result beats checked: %0d speed updates (%0d saturated), %0d zero-interval",
                 n_checked, n_speed, n_sat, n_zero);
        $display("covered all four direction steps, cpr 0/1/max, timestamp wrap, restarts");
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
